>>> hdl/assert_macros.svh
// Assertion macros shared by the traffic light crossing RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle brings a result in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tlp_pkg.sv
// Types, constants and phase tables of the traffic light crossing.
package tlp_pkg;

    localparam int SENSOR_W = 3;
    localparam int LAMP_W   = 3;
    localparam int DWELL_W  = 8;
    localparam int PHASE_W  = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 8'd5;

    typedef enum logic [PHASE_W-1:0] {
        PH_EW_GO    = 4'd0,
        PH_EW_WAIT  = 4'd1,
        PH_NS_GO    = 4'd2,
        PH_NS_WAIT  = 4'd3,
        PH_WALK     = 4'd4,
        PH_DW1_OFF  = 4'd5,
        PH_DW1_ON   = 4'd6,
        PH_DW2_OFF  = 4'd7,
        PH_DW2_ON   = 4'd8
    } phase_t;

    // Road lamp patterns: bits 5..3 east-west R/Y/G, bits 2..0 north-south R/Y/G.
    localparam logic [5:0] ROAD_EW_GO   = 6'h0C;
    localparam logic [5:0] ROAD_EW_WAIT = 6'h14;
    localparam logic [5:0] ROAD_NS_GO   = 6'h21;
    localparam logic [5:0] ROAD_NS_WAIT = 6'h22;
    localparam logic [5:0] ROAD_ALL_RED = 6'h24;
    localparam logic [5:0] ROAD_DARK    = 6'h00;

    // Pedestrian patterns: bit 3 walk, bit 1 don't walk.
    localparam logic [3:0] PED_WALK  = 4'h8;
    localparam logic [3:0] PED_DONT  = 4'h2;
    localparam logic [3:0] PED_DARK  = 4'h0;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_now;
        logic               dont_walk_lamp;
        logic               walk_lamp;
        logic [LAMP_W-1:0]  ns_lamps;
        logic [LAMP_W-1:0]  ew_lamps;
    } tlp_word_t;

    localparam int WORD_W = $bits(tlp_word_t);

    function automatic tlp_word_t phase_lamps(input phase_t ph);
        logic [5:0] road;
        logic [3:0] ped;
        tlp_word_t  w;
        unique case (ph)
            PH_EW_GO:   begin road = ROAD_EW_GO;   ped = PED_DONT; end
            PH_EW_WAIT: begin road = ROAD_EW_WAIT; ped = PED_DONT; end
            PH_NS_GO:   begin road = ROAD_NS_GO;   ped = PED_DONT; end
            PH_NS_WAIT: begin road = ROAD_NS_WAIT; ped = PED_DONT; end
            PH_WALK:    begin road = ROAD_ALL_RED; ped = PED_WALK; end
            PH_DW1_OFF: begin road = ROAD_ALL_RED; ped = PED_DARK; end
            PH_DW1_ON:  begin road = ROAD_ALL_RED; ped = PED_DONT; end
            PH_DW2_OFF: begin road = ROAD_ALL_RED; ped = PED_DARK; end
            PH_DW2_ON:  begin road = ROAD_ALL_RED; ped = PED_DONT; end
            default:    begin road = ROAD_DARK;    ped = PED_DARK; end
        endcase
        w.ew_lamps       = road[5:3];
        w.ns_lamps       = road[2:0];
        w.walk_lamp      = ped[3];
        w.dont_walk_lamp = ped[1];
        w.phase_now      = ph;
        return w;
    endfunction

    // Next phase by sensors: bit 2 pedestrian, bit 1 north-south car, bit 0 east-west car.
    function automatic phase_t next_phase(input phase_t ph, input logic [SENSOR_W-1:0] sens);
        phase_t nxt;
        case (ph)
            PH_EW_GO:   nxt = (sens[2:1] == 2'b00) ? PH_EW_GO : PH_EW_WAIT;
            PH_EW_WAIT: nxt = (sens[2:1] == 2'b10) ? PH_WALK : PH_NS_GO;
            PH_NS_GO:   nxt = (sens == 3'd0 || sens == 3'd2) ? PH_NS_GO : PH_NS_WAIT;
            PH_NS_WAIT: nxt = (!sens[2] && sens[0]) ? PH_EW_GO : PH_WALK;
            PH_WALK:    nxt = (sens == 3'd0 || sens == 3'd4) ? PH_WALK : PH_DW1_OFF;
            PH_DW1_OFF: nxt = PH_DW1_ON;
            PH_DW1_ON:  nxt = PH_DW2_OFF;
            PH_DW2_OFF: nxt = PH_DW2_ON;
            default:    nxt = PH_EW_GO;
        endcase
        return nxt;
    endfunction

endpackage

>>> hdl/tlp_phase_core.sv
// Phase register, dwell counter and lamp decode of the crossing.
`include "assert_macros.svh"

module tlp_phase_core
    import tlp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic [SENSOR_W-1:0]  sensors,
    input  logic [DWELL_W-1:0]   dwell_ticks,
    output tlp_word_t            word
);

    phase_t              phase_reg, phase_next;
    logic [DWELL_W-1:0]  tick_count_reg, tick_count_next;
    logic [DWELL_W-1:0]  dwell_eff;
    logic [DWELL_W:0]    cnt;
    logic                advance;

    always_comb
    begin
        dwell_eff = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
        cnt       = {1'b0, tick_count_reg} + (DWELL_W+1)'(1);
        advance   = cnt >= {1'b0, dwell_eff};
        word      = phase_lamps(phase_reg);
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        if (tick)
        begin
            if (advance)
            begin
                phase_next      = next_phase(phase_reg, sensors);
                tick_count_next = '0;
            end
            else
            begin
                tick_count_next = cnt[DWELL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_EW_GO;
            tick_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
        end
    end

    `ASSERT_ALWAYS(a_phase_range, phase_reg <= PH_DW2_ON, "phase left the table")
    `ASSERT_NEXT(a_count_clear, tick && advance, tick_count_reg == '0,
        "count not cleared at phase change")

endmodule

>>> hdl/tlp_out_skid.sv
// Two-entry output buffer: result register plus skid register.
`include "assert_macros.svh"

module tlp_out_skid
    import tlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tlp_word_t  in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output tlp_word_t  out_word
);

    logic       main_valid_reg, main_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    tlp_word_t  main_reg, main_next;
    tlp_word_t  skid_reg, skid_next;
    logic       accept_in;
    logic       take_out;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;
    assign accept_in = in_valid && in_ready;
    assign take_out  = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take_out || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_word;
                main_valid_next = accept_in;
            end
        end
        else if (accept_in)
        begin
            skid_next       = in_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_reg || main_valid_reg,
        "skid word held with empty result register")
    `ASSERT_NEXT(a_stall_to_skid, accept_in && main_valid_reg && !out_ready,
        skid_valid_reg, "stalled word not parked in skid register")

endmodule

>>> hdl/traffic_light_pedestrian_fsm_unit.sv
// Top level of the traffic light crossing with pedestrian walkway.
// The lamp word of an accepted tick word is registered in the result register, or in the skid register on a stall.
// Throughput: one tick word per cycle while the skid register is empty; phase and dwell count update at the tick.
// A two-entry output buffer keeps the slave side open while one result word stalls.
// Reset (rst_n low, asynchronous): phase east-west go, count zero, dwell 5, buffer empty.
module traffic_light_pedestrian_fsm_unit
    import tlp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Tick words in.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // [2:0] sensors, [7:3] zero
    // Lamp words out.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // [2:0] ew_lamps, [5:3] ns_lamps,
                                               // [6] walk_lamp, [7] dont_walk_lamp,
                                               // [11:8] phase_now, [15:12] zero
    // Dwell setting write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [DWELL_W-1:0]      cfg_data
);

    logic [DWELL_W-1:0] dwell_reg, dwell_next;
    logic               tick;
    tlp_word_t          core_word;
    tlp_word_t          out_word;

    // Take setting writes always; the user must let them arrive only while the block is idle (not enforced).
    assign cfg_ready = 1'b1;

    always_comb
    begin
        dwell_next = dwell_reg;
        if (cfg_valid && cfg_ready)
            dwell_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dwell_reg <= DWELL_RESET;
        else
            dwell_reg <= dwell_next;
    end

    // A tick advances the machine only when its word is accepted.
    assign tick = s_tvalid && s_tready;

    tlp_phase_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .sensors     (s_tdata[SENSOR_W-1:0]),
        .dwell_ticks (dwell_reg),
        .word        (core_word)
    );

    // Hold the lamp word of the phase current at the tick until the sink takes it.
    tlp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (core_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Pad the packed result with zeros up to whole bytes.
    assign m_tdata = {{(OUT_TDATA_W-WORD_W){1'b0}}, out_word};

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the traffic light crossing with pedestrian walkway.
module testbench;
    import tlp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word accepted on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 21;
    localparam int NUM_PHASES  = 9;

    // Lamp patterns and successor phases per phase, row index is the phase,
    // column index of the successor table is the sensor word of the sampling tick.
    localparam logic [5:0] ROAD_BY_PHASE [NUM_PHASES] = '{
        ROAD_EW_GO, ROAD_EW_WAIT, ROAD_NS_GO, ROAD_NS_WAIT,
        ROAD_ALL_RED, ROAD_ALL_RED, ROAD_ALL_RED, ROAD_ALL_RED, ROAD_ALL_RED
    };
    localparam logic [3:0] PED_BY_PHASE [NUM_PHASES] = '{
        PED_DONT, PED_DONT, PED_DONT, PED_DONT,
        PED_WALK, PED_DARK, PED_DONT, PED_DARK, PED_DONT
    };
    localparam logic [PHASE_W-1:0] SUCCESSOR [NUM_PHASES][8] = '{
        '{PH_EW_GO, PH_EW_GO, PH_EW_WAIT, PH_EW_WAIT,
          PH_EW_WAIT, PH_EW_WAIT, PH_EW_WAIT, PH_EW_WAIT},
        '{PH_NS_GO, PH_NS_GO, PH_NS_GO, PH_NS_GO,
          PH_WALK, PH_WALK, PH_NS_GO, PH_NS_GO},
        '{PH_NS_GO, PH_NS_WAIT, PH_NS_GO, PH_NS_WAIT,
          PH_NS_WAIT, PH_NS_WAIT, PH_NS_WAIT, PH_NS_WAIT},
        '{PH_WALK, PH_EW_GO, PH_WALK, PH_EW_GO,
          PH_WALK, PH_WALK, PH_WALK, PH_WALK},
        '{PH_WALK, PH_DW1_OFF, PH_DW1_OFF, PH_DW1_OFF,
          PH_WALK, PH_DW1_OFF, PH_DW1_OFF, PH_DW1_OFF},
        '{PH_DW1_ON, PH_DW1_ON, PH_DW1_ON, PH_DW1_ON,
          PH_DW1_ON, PH_DW1_ON, PH_DW1_ON, PH_DW1_ON},
        '{PH_DW2_OFF, PH_DW2_OFF, PH_DW2_OFF, PH_DW2_OFF,
          PH_DW2_OFF, PH_DW2_OFF, PH_DW2_OFF, PH_DW2_OFF},
        '{PH_DW2_ON, PH_DW2_ON, PH_DW2_ON, PH_DW2_ON,
          PH_DW2_ON, PH_DW2_ON, PH_DW2_ON, PH_DW2_ON},
        '{PH_EW_GO, PH_EW_GO, PH_EW_GO, PH_EW_GO,
          PH_EW_GO, PH_EW_GO, PH_EW_GO, PH_EW_GO}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [2:0] sensors, [7:3] zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [2:0] ew_lamps, [5:3] ns_lamps, [6] walk_lamp,
                                        // [7] dont_walk_lamp, [11:8] phase_now, [15:12] zero
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [DWELL_W-1:0]     cfg_data;

    // Shadow copy of the crossing state and of the dwell setting.
    logic [PHASE_W-1:0]     cur_phase;
    logic [DWELL_W-1:0]     tick_cnt;
    logic [DWELL_W-1:0]     dwell_setting;

    // Lamp words still owed by the block, oldest first.
    tlp_word_t              lamp_words_due [$];

    int                     n_err;
    int                     stall_cycles;
    // Set to hold both sides busy with no idle cycles.
    bit                     calm;

    traffic_light_pedestrian_fsm_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the lamp word of one tick and advance the shadow state.
    // The word shows the phase current at the start of the tick; the phase only
    // moves once the count reaches the dwell, and a dwell of zero counts as one.
    function automatic tlp_word_t advance_crossing(input logic [SENSOR_W-1:0] sens);
        tlp_word_t          w;
        logic [5:0]         road;
        logic [3:0]         ped;
        logic [DWELL_W:0]   cnt;
        logic [DWELL_W-1:0] eff_dwell;
        bit                 known;
        known = cur_phase < NUM_PHASES;
        road  = known ? ROAD_BY_PHASE[cur_phase] : ROAD_DARK;
        ped   = known ? PED_BY_PHASE[cur_phase] : PED_DARK;
        w.ew_lamps       = road[5:3];
        w.ns_lamps       = road[2:0];
        w.walk_lamp      = ped[3];
        w.dont_walk_lamp = ped[1];
        w.phase_now      = cur_phase;
        eff_dwell = (dwell_setting == '0) ? 8'd1 : dwell_setting;
        cnt       = {1'b0, tick_cnt} + 9'd1;
        if (cnt >= {1'b0, eff_dwell})
        begin
            cur_phase = known ? SUCCESSOR[cur_phase][sens] : PH_EW_GO;
            tick_cnt  = '0;
        end
        else
        begin
            tick_cnt = cnt[DWELL_W-1:0];
        end
        return w;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            n_err++;
        end
    endfunction

    // Present one tick word, with a random idle gap ahead of it, and hold it
    // until the slave side takes it. The word stays up on return so that
    // back-to-back ticks need no gap.
    task automatic send_tick(input logic [SENSOR_W-1:0] sens);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-SENSOR_W){1'b0}}, sens};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lamp_words_due.push_back(advance_crossing(sens));
    endtask

    // Drop the tick stream and hold until every owed lamp word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (lamp_words_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the dwell setting with the block idle.
    task automatic write_dwell(input logic [DWELL_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        dwell_setting = value;
    endtask

    // Reset dwell of 5: the first four ticks hold east-west go whatever the
    // sensors say; the fifth samples all sensors set.
    task automatic test_reset_dwell();
        send_tick(3'd0);
        send_tick(3'd1);
        send_tick(3'd2);
        send_tick(3'd4);
        send_tick(3'd7);
    endtask

    // Dwell of zero advances every tick; steer through every phase,
    // including the walk and both don't-walk flashes.
    task automatic test_phase_walk();
        write_dwell(8'd0);
        send_tick(3'd4);    // east-west wait, pedestrian only: to walk
        send_tick(3'd1);    // walk ends on a car
        send_tick(3'd0);
        send_tick(3'd5);
        send_tick(3'd6);
        send_tick(3'd3);    // last flash back to east-west go
        send_tick(3'd0);    // no demand: stay
        send_tick(3'd2);    // north-south car: to east-west wait
        send_tick(3'd0);
        send_tick(3'd1);    // north-south go to wait on an east-west car
        send_tick(3'd0);    // north-south wait with nobody: to walk
        send_tick(3'd7);
    endtask

    // Lower the dwell below a count already run up: the very next tick moves.
    task automatic test_dwell_lowered();
        int i;
        write_dwell(8'd8);
        for (i = 0; i < 6; i++)
            send_tick(3'($urandom_range(0, 7)));
        write_dwell(8'd2);
        send_tick(3'd6);
        send_tick(3'd1);
    endtask

    // Segments of random traffic at several dwell settings, the extremes among
    // them. Sensors often persist for a while, as real traffic does, so the
    // machine gets into every phase and back out.
    task automatic test_random_traffic();
        int                  plan [$];
        int                  seg;
        int                  i;
        int                  n_ticks;
        logic [SENSOR_W-1:0] sens;
        plan = '{1, 3, 0, 2, 255, 6, 1, 4, 7, 0};
        plan[9] = $urandom_range(1, 16);
        sens = '0;
        for (seg = 0; seg < plan.size(); seg++)
        begin
            write_dwell(plan[seg][DWELL_W-1:0]);
            n_ticks = (plan[seg] == 255) ? 540 : 120;
            // One segment runs with no idling on either side.
            calm = (seg == 3);
            for (i = 0; i < n_ticks; i++)
            begin
                if ($urandom_range(0, 99) >= 30)
                    sens = 3'($urandom_range(0, 7));
                send_tick(sens);
                if (seg % 3 == 0 && i == n_ticks / 2)
                    drain_results();
            end
        end
        calm = 1'b0;
    endtask

    // Master side: stall at random, never during the calm stretch.
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each accepted lamp word with the oldest one owed.
    always @(posedge clk)
    begin : lamp_check
        tlp_word_t exp_w;
        tlp_word_t got_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lamp_words_due.size() == 0)
            begin
                $display("%0t: unexpected lamp word, expected none, actual %h", $time, m_tdata);
                n_err++;
            end
            else
            begin
                exp_w = lamp_words_due.pop_front();
                got_w = m_tdata[WORD_W-1:0];
                check_field("ew_lamps", exp_w.ew_lamps, got_w.ew_lamps);
                check_field("ns_lamps", exp_w.ns_lamps, got_w.ns_lamps);
                check_field("walk_lamp", exp_w.walk_lamp, got_w.walk_lamp);
                check_field("dont_walk_lamp", exp_w.dont_walk_lamp, got_w.dont_walk_lamp);
                check_field("phase_now", exp_w.phase_now, got_w.phase_now);
                check_field("tdata pad", 0, m_tdata[OUT_TDATA_W-1:WORD_W]);
            end
        end
    end

    // Hang detector: count cycles in which no channel moves a word.
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : main_flow
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        calm          = 1'b0;
        n_err         = 0;
        cur_phase     = PH_EW_GO;
        tick_cnt      = '0;
        dwell_setting = DWELL_RESET;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_dwell();
        test_phase_walk();
        test_dwell_lowered();
        test_random_traffic();

        // Let the last lamp words out, then wait for any stray lamp words before the verdict.
        drain_results();
        repeat (4) @(posedge clk);
        if (n_err == 0 && lamp_words_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> traffic_light_pedestrian_fsm_unit.f
+incdir+hdl
hdl/tlp_pkg.sv
hdl/tlp_phase_core.sv
hdl/tlp_out_skid.sv
hdl/traffic_light_pedestrian_fsm_unit.sv
dv/testbench.sv
